[design/pct_pkg.sv]
// Shared types, codes and constants of the pomodoro countdown timer.
// No dependencies; every other file of the block imports this package.

package pct_pkg;

  localparam int MAX_CHOICES = 4;
  localparam int CFG_AW      = 5;
  localparam int MIN_W       = 7;
  localparam int MS_W        = 23;
  localparam int SEC_W       = 13;
  localparam int DT_W        = 16;
  localparam int X_W         = 9;
  localparam int Y_W         = 8;

  typedef enum logic [1:0] {
    RUN_IDLE   = 2'd0,
    RUN_GO     = 2'd1,
    RUN_PAUSED = 2'd2
  } pct_run_t;

  localparam logic PHASE_WORK  = 1'b0;
  localparam logic PHASE_BREAK = 1'b1;
  localparam logic CMD_TICK    = 1'b0;
  localparam logic CMD_TAP     = 1'b1;

  // register indexes on the configuration port
  localparam logic [2:0] REG_WORK_A = 3'd0;
  localparam logic [2:0] REG_WORK_B = 3'd1;
  localparam logic [2:0] REG_WORK_C = 3'd2;
  localparam logic [2:0] REG_WORK_D = 3'd3;
  localparam logic [2:0] REG_BREAK  = 3'd4;

  localparam logic [MIN_W-1:0] WORK_A_RST = 7'd15;
  localparam logic [MIN_W-1:0] WORK_B_RST = 7'd25;
  localparam logic [MIN_W-1:0] WORK_C_RST = 7'd45;
  localparam logic [MIN_W-1:0] WORK_D_RST = 7'd60;
  localparam logic [MIN_W-1:0] BREAK_RST  = 7'd5;
  localparam logic [1:0]       CHOICE_RST = 2'd1;
  localparam logic [MS_W-1:0]  REMAIN_RST = 23'd1500000;

  localparam logic [15:0] MS_PER_MIN = 16'd60000;

  // touch layout
  localparam logic [Y_W-1:0] ROW_TOP  = 8'd146;
  localparam logic [Y_W-1:0] ROW_BOT  = 8'd190;
  localparam logic [Y_W-1:0] BTN_TOP  = 8'd192;
  localparam logic [X_W-1:0] START_LO = 9'd16;
  localparam logic [X_W-1:0] START_HI = 9'd156;
  localparam logic [X_W-1:0] RESET_LO = 9'd164;
  localparam logic [X_W-1:0] RESET_HI = 9'd304;
  localparam int CHIP_LEFT  = 16;
  localparam int CHIP_PITCH = 76;
  localparam int CHIP_SPAN  = 68;

  // ceil(ms / 1000) = floor((ms + 999) * RECIP >> SHIFT), exact below 2^24
  localparam logic [23:0] SEC_ROUND = 24'd999;
  localparam logic [24:0] SEC_RECIP = 25'd17179870;
  localparam int          SEC_SHIFT = 34;

  function automatic logic [X_W-1:0] chip_lo(input int idx);
    return X_W'(CHIP_LEFT + CHIP_PITCH * idx);
  endfunction

  function automatic logic [X_W-1:0] chip_hi(input int idx);
    return X_W'(CHIP_LEFT + CHIP_PITCH * idx + CHIP_SPAN);
  endfunction

  typedef struct packed {
    logic            cmd;
    logic [DT_W-1:0] elapsed_ms;
    logic [X_W-1:0]  tap_x;
    logic [Y_W-1:0]  tap_y;
  } pct_item_t;

  typedef struct packed {
    logic [MAX_CHOICES-1:0][MIN_W-1:0] work_min;
    logic [MIN_W-1:0]                  break_min;
  } pct_cfg_t;

  typedef struct packed {
    logic            session_done;
    logic            phase;
    logic [1:0]      run_state;
    logic [1:0]      choice;
    logic [MS_W-1:0] remaining_ms;
  } pct_res_t;

  typedef struct packed {
    pct_res_t         res;
    logic [SEC_W-1:0] remaining_seconds;
  } pct_out_t;

endpackage

[design/pct_cfg_regs.sv]
// Configuration register file of the pomodoro timer: phase lengths in minutes.
// Depends on pct_pkg.

module pct_cfg_regs (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [pct_pkg::CFG_AW-1:0] paddr,
  input  logic [31:0]               pwdata,
  output logic [31:0]               prdata,
  output pct_pkg::pct_cfg_t         cfg
);
  import pct_pkg::*;

  pct_cfg_t   cfg_r;
  logic [2:0] idx;
  logic       wr_en;

  assign idx   = paddr[CFG_AW-1:2];
  assign wr_en = psel & penable & pwrite;
  assign cfg   = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.work_min[0] <= WORK_A_RST;
      cfg_r.work_min[1] <= WORK_B_RST;
      cfg_r.work_min[2] <= WORK_C_RST;
      cfg_r.work_min[3] <= WORK_D_RST;
      cfg_r.break_min   <= BREAK_RST;
    end else if (wr_en) begin
      case (idx)
        REG_WORK_A: cfg_r.work_min[0] <= pwdata[MIN_W-1:0];
        REG_WORK_B: cfg_r.work_min[1] <= pwdata[MIN_W-1:0];
        REG_WORK_C: cfg_r.work_min[2] <= pwdata[MIN_W-1:0];
        REG_WORK_D: cfg_r.work_min[3] <= pwdata[MIN_W-1:0];
        REG_BREAK:  cfg_r.break_min   <= pwdata[MIN_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_WORK_A: prdata = {25'd0, cfg_r.work_min[0]};
      REG_WORK_B: prdata = {25'd0, cfg_r.work_min[1]};
      REG_WORK_C: prdata = {25'd0, cfg_r.work_min[2]};
      REG_WORK_D: prdata = {25'd0, cfg_r.work_min[3]};
      REG_BREAK:  prdata = {25'd0, cfg_r.break_min};
      default:    prdata = 32'd0;
    endcase
  end

endmodule

[design/pct_core.sv]
// Timer state and per-item update: hit-testing, run state machine, countdown.
// Depends on pct_pkg.

module pct_core #(
  parameter int NUM_CHOICES = 4
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               fire,
  input  pct_pkg::pct_item_t item,
  input  pct_pkg::pct_cfg_t  cfg,
  output pct_pkg::pct_res_t  res
);
  import pct_pkg::*;

  pct_run_t         run_r, run_nxt;
  logic             phase_r, phase_nxt;
  logic [1:0]       choice_r, choice_nxt;
  logic [MS_W-1:0]  remain_r, remain_nxt;
  logic             hidden_r, hidden_nxt;
  pct_res_t         res_r, res_nxt;

  logic [MAX_CHOICES-1:0] chip_hit;
  logic [1:0]             chip_sel;
  logic                   in_row, on_start, on_reset;
  logic                   done, load_idle, load_break;
  logic [1:0]             idle_sel;
  logic [MIN_W-1:0]       len_min;
  logic [MS_W-1:0]        len_ms;

  // hit-test the tap against the chips and buttons
  always_comb begin
    chip_sel = 2'd0;
    for (int i = 0; i < MAX_CHOICES; i++) begin
      chip_hit[i] = (i < NUM_CHOICES) && (item.tap_x >= chip_lo(i)) &&
                    (item.tap_x <= chip_hi(i));
    end
    for (int i = MAX_CHOICES - 1; i >= 0; i--) begin
      if (chip_hit[i]) chip_sel = 2'(i);
    end
  end

  assign in_row   = !hidden_r && (item.tap_y >= ROW_TOP) && (item.tap_y <= ROW_BOT);
  assign on_start = (item.tap_y >= BTN_TOP) && (item.tap_x >= START_LO) &&
                    (item.tap_x <= START_HI);
  assign on_reset = (item.tap_y >= BTN_TOP) && (item.tap_x >= RESET_LO) &&
                    (item.tap_x <= RESET_HI);

  // next state
  always_comb begin
    run_nxt    = run_r;
    phase_nxt  = phase_r;
    choice_nxt = choice_r;
    remain_nxt = remain_r;
    hidden_nxt = hidden_r;
    done       = 1'b0;
    load_idle  = 1'b0;
    load_break = 1'b0;
    idle_sel   = choice_r;
    case (item.cmd)
      CMD_TICK: begin
        if (run_r == RUN_GO) begin
          if (remain_r > MS_W'(item.elapsed_ms)) begin
            remain_nxt = remain_r - MS_W'(item.elapsed_ms);
          end else begin
            // phase over: drop the leftover time
            done = 1'b1;
            if (phase_r == PHASE_WORK) load_break = 1'b1;
            else                       load_idle  = 1'b1;
          end
        end
      end
      CMD_TAP: begin
        if (in_row) begin
          if (|chip_hit) begin
            load_idle = 1'b1;
            idle_sel  = chip_sel;
          end
        end else if (on_start) begin
          if (run_r == RUN_GO) begin
            run_nxt = RUN_PAUSED;
          end else begin
            if (run_r == RUN_IDLE) hidden_nxt = 1'b1;
            run_nxt = RUN_GO;
          end
        end else if (on_reset) begin
          load_idle = 1'b1;
        end
      end
      default: ;
    endcase

    len_min = load_break ? cfg.break_min : cfg.work_min[idle_sel];
    len_ms  = MS_W'(len_min) * MS_W'(MS_PER_MIN);

    if (load_break) begin
      phase_nxt  = PHASE_BREAK;
      remain_nxt = len_ms;
      run_nxt    = RUN_GO;
    end
    if (load_idle) begin
      choice_nxt = idle_sel;
      phase_nxt  = PHASE_WORK;
      run_nxt    = RUN_IDLE;
      remain_nxt = len_ms;
      hidden_nxt = 1'b0;
    end
  end

  // result of the item
  always_comb begin
    res_nxt.session_done = done;
    res_nxt.phase        = phase_nxt;
    res_nxt.run_state    = run_nxt;
    res_nxt.choice       = choice_nxt;
    res_nxt.remaining_ms = remain_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r    <= RUN_IDLE;
      phase_r  <= PHASE_WORK;
      choice_r <= CHOICE_RST;
      remain_r <= REMAIN_RST;
      hidden_r <= 1'b0;
    end else if (fire) begin
      run_r    <= run_nxt;
      phase_r  <= phase_nxt;
      choice_r <= choice_nxt;
      remain_r <= remain_nxt;
      hidden_r <= hidden_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) res_r <= res_nxt;
  end

  assign res = res_r;

endmodule

[design/pct_sec_stage.sv]
// Output stage: rounds remaining milliseconds up to whole seconds by a
// reciprocal multiply and registers the finished result. Depends on pct_pkg.

module pct_sec_stage (
  input  logic              clk,
  input  logic              load,
  input  pct_pkg::pct_res_t res,
  output pct_pkg::pct_out_t out
);
  import pct_pkg::*;

  logic [23:0] round_sum;
  logic [48:0] prod;
  pct_out_t    out_r;

  assign round_sum = {1'b0, res.remaining_ms} + SEC_ROUND;
  assign prod      = 49'(round_sum) * 49'(SEC_RECIP);

  always_ff @(posedge clk) begin
    if (load) begin
      out_r.res               <= res;
      out_r.remaining_seconds <= prod[SEC_SHIFT +: SEC_W];
    end
  end

  assign out = out_r;

endmodule

[design/pomodoro_countdown_timer_top.sv]
// Top level of the pomodoro work/break countdown timer: stream ports, APB
// register port and the three-stage item pipeline. Depends on pct_pkg,
// pct_cfg_regs, pct_core and pct_sec_stage.
//
//   Channel | Dir | Handshake               | Payload
//   --------+-----+-------------------------+---------------------------------
//   in_     | in  | in_tvalid / in_tready   | tuser cmd, tdata tick/tap fields
//   out_    | out | out_tvalid / out_tready | tlast session_done, tdata state
//   cfg_    | in  | psel, penable, pready=1 | five 7-bit minute registers
//
// One item per cycle sustained while out_tready holds high; each item passes
// from acceptance to its result through the input register, the state update into
// the core result register and the seconds rounding into the output register.
// Reset (rst_n low, synchronous) empties the pipeline and restores the timer
// state and the minute registers to their defaults; no clearing pass.
// Stalls on out_tready fill empty stages first; in_tready drops only when the
// input register is full and cannot move on.

module pomodoro_countdown_timer_top #(
  parameter int NUM_CHOICES = 4
) (
  input  logic                       clk,
  input  logic                       rst_n,
  // input item
  input  logic                       in_tvalid,
  output logic                       in_tready,
  input  logic [39:0]                in_tdata,   // elapsed_ms[15:0], tap_x[24:16], tap_y[32:25]
  input  logic                       in_tuser,   // cmd
  // result item
  output logic                       out_tvalid,
  input  logic                       out_tready,
  output logic [47:0]                out_tdata,  // phase[0], run_state[2:1], choice[4:3],
                                                 // remaining_ms[27:5], remaining_seconds[40:28]
  output logic                       out_tlast,  // session_done
  // configuration
  input  logic                       cfg_psel,
  input  logic                       cfg_penable,
  input  logic                       cfg_pwrite,
  input  logic [pct_pkg::CFG_AW-1:0] cfg_paddr,
  input  logic [31:0]                cfg_pwdata,
  output logic [31:0]                cfg_prdata,
  output logic                       cfg_pready
);
  import pct_pkg::*;

  pct_item_t s1_item_r;
  logic      s1_valid_r, s1_valid_nxt;
  logic      s2_valid_r, s2_valid_nxt;
  logic      out_valid_r, out_valid_nxt;
  logic      s1_ok, s2_ok, s3_ok;
  logic      fire, load_out, in_take;
  pct_cfg_t  cfg;
  pct_res_t  core_res;
  pct_out_t  out_res;

  assign cfg_pready = 1'b1;

  pct_cfg_regs u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (cfg_psel),
    .penable (cfg_penable),
    .pwrite  (cfg_pwrite),
    .paddr   (cfg_paddr),
    .pwdata  (cfg_pwdata),
    .prdata  (cfg_prdata),
    .cfg     (cfg)
  );

  // a stage may advance when the one after it is empty or advancing too
  assign s3_ok     = !out_valid_r || out_tready;
  assign s2_ok     = !s2_valid_r || s3_ok;
  assign s1_ok     = !s1_valid_r || s2_ok;
  assign in_tready = s1_ok;
  assign in_take   = in_tvalid && s1_ok;
  assign fire      = s1_valid_r && s2_ok;
  assign load_out  = s2_valid_r && s3_ok;

  assign s1_valid_nxt  = s1_ok ? in_tvalid : 1'b1;
  assign s2_valid_nxt  = fire || (s2_valid_r && !s3_ok);
  assign out_valid_nxt = load_out || (out_valid_r && !out_tready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      s2_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      s2_valid_r  <= s2_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // capture the input item
  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_item_r.cmd        <= in_tuser;
      s1_item_r.elapsed_ms <= in_tdata[15:0];
      s1_item_r.tap_x      <= in_tdata[24:16];
      s1_item_r.tap_y      <= in_tdata[32:25];
    end
  end

  // state update happens exactly once per item, when it leaves the input register
  pct_core #(
    .NUM_CHOICES (NUM_CHOICES)
  ) u_core (
    .clk   (clk),
    .rst_n (rst_n),
    .fire  (fire),
    .item  (s1_item_r),
    .cfg   (cfg),
    .res   (core_res)
  );

  pct_sec_stage u_sec (
    .clk  (clk),
    .load (load_out),
    .res  (core_res),
    .out  (out_res)
  );

  assign out_tvalid = out_valid_r;
  assign out_tlast  = out_res.res.session_done;
  assign out_tdata  = {7'd0, out_res.remaining_seconds, out_res.res.remaining_ms,
                       out_res.res.choice, out_res.res.run_state, out_res.res.phase};

  // a finished break lands in idle work
  a_break_end_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_res.res.session_done && out_res.res.phase == PHASE_WORK)
      |-> (out_res.res.run_state == RUN_IDLE))
    else $error("break ended but timer not idle");

  // a finished work phase starts the break running
  a_work_end_break: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_res.res.session_done && out_res.res.phase == PHASE_BREAK)
      |-> (out_res.res.run_state == RUN_GO))
    else $error("work ended but break not running");

  // seconds are the milliseconds rounded up
  a_sec_round: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |->
      ((32'(out_res.remaining_seconds) * 32'd1000 >= 32'(out_res.res.remaining_ms)) &&
       (32'(out_res.remaining_seconds) * 32'd1000 < 32'(out_res.res.remaining_ms) + 32'd1000)))
    else $error("remaining_seconds not ceil of remaining_ms");

  // the core result register only holds an item when the core was fired
  a_s2_source: assert property (@(posedge clk) disable iff (!rst_n)
    (s2_valid_r && !$past(s2_valid_r)) |-> $past(fire))
    else $error("core result valid without an update");

endmodule

[tb/sv/tb_pomodoro_countdown_timer_top.sv]
// Self-checking testbench for pomodoro_countdown_timer_top: drives tick and tap
// items, predicts every status item and checks each field as it leaves.
// Depends on pct_pkg and the RTL of the block; reads no files.

module tb_pomodoro_countdown_timer_top;
  import pct_pkg::*;

  localparam int CHOICES = 4;

  // Screen layout, taken from the block's description.
  localparam int ROW_Y_LO   = 146;
  localparam int ROW_Y_HI   = 190;
  localparam int CHIP_X0    = 16;
  localparam int CHIP_STEP  = 76;
  localparam int CHIP_WIDTH = 68;
  localparam int BTN_Y_LO   = 192;
  localparam int GO_X_LO    = 16;
  localparam int GO_X_HI    = 156;
  localparam int CLR_X_LO   = 164;
  localparam int CLR_X_HI   = 304;

  logic        clk         = 1'b0;
  logic        rst_n       = 1'b0;
  logic        in_tvalid   = 1'b0;
  logic        in_tready;
  logic [39:0] in_tdata    = '0;
  logic        in_tuser    = 1'b0;
  logic        out_tvalid;
  logic        out_tready  = 1'b0;
  logic [47:0] out_tdata;
  logic        out_tlast;
  logic        cfg_psel    = 1'b0;
  logic        cfg_penable = 1'b0;
  logic        cfg_pwrite  = 1'b0;
  logic [CFG_AW-1:0] cfg_paddr = '0;
  logic [31:0] cfg_pwdata  = '0;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  // Timer state as the block should hold it after every accepted item.
  logic             tmr_phase;
  pct_run_t         tmr_run;
  logic [1:0]       tmr_choice;
  logic [MS_W-1:0]  tmr_remain;
  logic             tmr_chips_hidden;
  logic [MIN_W-1:0] work_min [CHOICES];
  logic [MIN_W-1:0] break_min;

  pct_out_t status_due [$];   // predicted status items, oldest first
  int       mismatch_count = 0;
  int       sink_hold      = 0;   // cycles the result side must hold off
  bit       no_gaps        = 1'b0;

  pomodoro_countdown_timer_top #(.NUM_CHOICES(CHOICES)) dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),    // elapsed_ms[15:0], tap_x[24:16], tap_y[32:25]
    .in_tuser    (in_tuser),    // cmd
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),   // phase[0], run_state[2:1], choice[4:3],
                                // remaining_ms[27:5], remaining_seconds[40:28]
    .out_tlast   (out_tlast),   // session_done
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  always #6 clk = ~clk;

  // ---------------------------------------------------------------------------
  // Timer prediction
  // ---------------------------------------------------------------------------

  function automatic logic [MS_W-1:0] minutes_to_ms(logic [MIN_W-1:0] m);
    return MS_W'(32'(m) * 32'd60000);
  endfunction

  // Reload idle work at the length of the given chip and show the chips.
  function automatic void return_to_idle(logic [1:0] sel);
    tmr_choice       = sel;
    tmr_phase        = PHASE_WORK;
    tmr_run          = RUN_IDLE;
    tmr_remain       = minutes_to_ms(work_min[sel]);
    tmr_chips_hidden = 1'b0;
  endfunction

  function automatic void reset_timer();
    work_min[0] = 7'd15;
    work_min[1] = 7'd25;
    work_min[2] = 7'd45;
    work_min[3] = 7'd60;
    break_min   = 7'd5;
    tmr_phase        = PHASE_WORK;
    tmr_run          = RUN_IDLE;
    tmr_choice       = 2'd1;
    tmr_remain       = 23'd1500000;
    tmr_chips_hidden = 1'b0;
  endfunction

  // Apply one tick or tap and return the status the block must report.
  function automatic pct_out_t advance_timer(logic c, logic [DT_W-1:0] dt,
                                             logic [X_W-1:0] x, logic [Y_W-1:0] y);
    pct_out_t st;
    logic     done;
    logic     hit;
    int       i;
    done = 1'b0;
    hit  = 1'b0;
    if (c == CMD_TICK) begin
      if (tmr_run == RUN_GO) begin
        if (tmr_remain > MS_W'(dt)) begin
          tmr_remain = tmr_remain - MS_W'(dt);
        end else begin
          // Drop any leftover time; work rolls into break, break into idle.
          done = 1'b1;
          if (tmr_phase == PHASE_WORK) begin
            tmr_phase  = PHASE_BREAK;
            tmr_remain = minutes_to_ms(break_min);
          end else begin
            return_to_idle(tmr_choice);
          end
        end
      end
    end else if (!tmr_chips_hidden && y >= ROW_Y_LO && y <= ROW_Y_HI) begin
      for (i = 0; i < CHOICES; i++) begin
        if (!hit && x >= CHIP_X0 + CHIP_STEP * i &&
            x <= CHIP_X0 + CHIP_STEP * i + CHIP_WIDTH) begin
          hit = 1'b1;
          return_to_idle(2'(i));
        end
      end
    end else if (y >= BTN_Y_LO && x >= GO_X_LO && x <= GO_X_HI) begin
      if (tmr_run == RUN_GO) begin
        tmr_run = RUN_PAUSED;
      end else begin
        if (tmr_run == RUN_IDLE) tmr_chips_hidden = 1'b1;
        tmr_run = RUN_GO;
      end
    end else if (y >= BTN_Y_LO && x >= CLR_X_LO && x <= CLR_X_HI) begin
      return_to_idle(tmr_choice);
    end
    st.res.session_done    = done;
    st.res.phase           = tmr_phase;
    st.res.run_state       = tmr_run;
    st.res.choice          = tmr_choice;
    st.res.remaining_ms    = tmr_remain;
    st.remaining_seconds   = SEC_W'((32'(tmr_remain) + 32'd999) / 32'd1000);
    return st;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  task automatic note_failure(string what);
    mismatch_count++;
    if (mismatch_count <= 10) $display("%0t: %s", $realtime, what);
  endtask

  // Mostly zero or short gaps, now and then a long one.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (no_gaps) return 0;
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  // Offer one item and hold it until accepted. Valid stays high on return so
  // that a back-to-back item never sees valid drop and rise in one step.
  task automatic send_item(logic c, logic [DT_W-1:0] dt, logic [X_W-1:0] x,
                           logic [Y_W-1:0] y);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= c;
    in_tdata  <= {7'b0, y, x, dt};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    status_due.push_back(advance_timer(c, dt, x, y));
  endtask

  // Drop valid and wait for every predicted status item, within a limit.
  task automatic settle_results();
    int waited;
    waited = 0;
    in_tvalid <= 1'b0;
    while (status_due.size() != 0 && waited < 4000) begin
      @(posedge clk);
      waited++;
    end
    while (status_due.size() != 0) begin
      void'(status_due.pop_front());
      note_failure("status item never arrived");
    end
    @(posedge clk);
  endtask

  // Setup then access phase of a register write; the register takes the value at the access edge.
  task automatic write_minutes(logic [2:0] idx, logic [MIN_W-1:0] minutes);
    @(posedge clk);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= {idx, 2'b00};
    cfg_pwdata  <= 32'(minutes);
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    if (idx == REG_BREAK) break_min = minutes;
    else work_min[idx[1:0]] = minutes;
  endtask

  task automatic load_lengths(logic [MIN_W-1:0] a, logic [MIN_W-1:0] b,
                              logic [MIN_W-1:0] c, logic [MIN_W-1:0] d,
                              logic [MIN_W-1:0] brk);
    settle_results();
    write_minutes(REG_WORK_A, a);
    write_minutes(REG_WORK_B, b);
    write_minutes(REG_WORK_C, c);
    write_minutes(REG_WORK_D, d);
    write_minutes(REG_BREAK,  brk);
  endtask

  // Pick a random item, steered by the predicted state so that runs reach the
  // end of work and break phases; the rest is noise over every field bit.
  task automatic pick_item(output logic c, output logic [DT_W-1:0] dt,
                           output logic [X_W-1:0] x, output logic [Y_W-1:0] y);
    int r;
    int k;
    int lo;
    r  = $urandom_range(0, 99);
    k  = $urandom_range(0, CHOICES - 1);
    lo = CHIP_X0 + CHIP_STEP * k;
    c  = CMD_TAP;
    dt = DT_W'($urandom_range(0, 65535));
    x  = X_W'($urandom_range(0, 511));
    y  = Y_W'($urandom_range(0, 255));
    if (r < 10) begin
      c = 1'($urandom_range(0, 1));
    end else if (tmr_run == RUN_GO) begin
      if (r < 75) begin
        c = CMD_TICK;
        r = $urandom_range(0, 9);
        if (r < 3) dt = DT_W'($urandom_range(0, 2000));
        else if (r < 5 && tmr_remain <= 65535) dt = DT_W'(tmr_remain);
        else if (r < 6 && tmr_remain <= 65536 && tmr_remain > 0)
          dt = DT_W'(tmr_remain - 1);
        else dt = DT_W'($urandom_range(30000, 65535));
      end else if (r < 85) begin
        x = X_W'($urandom_range(GO_X_LO, GO_X_HI));
        y = Y_W'($urandom_range(BTN_Y_LO, 255));
      end else if (r < 90) begin
        x = X_W'($urandom_range(CLR_X_LO, CLR_X_HI));
        y = Y_W'($urandom_range(BTN_Y_LO, 255));
      end else begin
        x = X_W'($urandom_range(lo, lo + CHIP_WIDTH));
        y = Y_W'($urandom_range(ROW_Y_LO, ROW_Y_HI));
      end
    end else begin
      if (r < 50) begin
        x = X_W'($urandom_range(GO_X_LO, GO_X_HI));
        y = Y_W'($urandom_range(BTN_Y_LO, 255));
      end else if (r < 68) begin
        x = X_W'($urandom_range(lo, lo + CHIP_WIDTH));
        y = Y_W'($urandom_range(ROW_Y_LO, ROW_Y_HI));
      end else if (r < 76) begin
        x = X_W'($urandom_range(CLR_X_LO, CLR_X_HI));
        y = Y_W'($urandom_range(BTN_Y_LO, 255));
      end else if (r < 86) begin
        c = CMD_TICK;
      end else begin
        // between or beside the chips
        x = (k < CHOICES - 1) ? X_W'($urandom_range(lo + CHIP_WIDTH + 1, lo + CHIP_STEP - 1))
                              : X_W'($urandom_range(0, CHIP_X0 - 1));
        y = Y_W'($urandom_range(ROW_Y_LO, ROW_Y_HI));
      end
    end
  endtask

  task automatic send_random(int count);
    logic             c;
    logic [DT_W-1:0]  dt;
    logic [X_W-1:0]   x;
    logic [Y_W-1:0]   y;
    repeat (count) begin
      pick_item(c, dt, x, y);
      send_item(c, dt, x, y);
    end
  endtask

  // ---------------------------------------------------------------------------
  // Result checking
  // ---------------------------------------------------------------------------

  task automatic compare_field(string name, int want, int got);
    if (want != got)
      note_failure($sformatf("%s mismatch: expected %0d, got %0d", name, want, got));
  endtask

  // Match every accepted status item against the oldest prediction.
  always @(posedge clk) begin : status_check
    pct_out_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (status_due.size() == 0) begin
        note_failure($sformatf("unexpected status item tdata=%h tlast=%b",
                               out_tdata, out_tlast));
      end else begin
        want = status_due.pop_front();
        compare_field("session_done", want.res.session_done, out_tlast);
        compare_field("phase", want.res.phase, out_tdata[0]);
        compare_field("run_state", want.res.run_state, out_tdata[2:1]);
        compare_field("choice", want.res.choice, out_tdata[4:3]);
        compare_field("remaining_ms", want.res.remaining_ms, out_tdata[27:5]);
        compare_field("remaining_seconds", want.remaining_seconds, out_tdata[40:28]);
      end
    end
  end

  // Result side: alternate ready and stall stretches; honor a requested
  // hold-off cycle by cycle, and stay ready while gaps are switched off.
  initial begin : status_sink
    int   stretch_left;
    logic level;
    stretch_left = 0;
    level        = 1'b0;
    forever begin
      @(posedge clk);
      if (sink_hold > 0) begin
        out_tready <= 1'b0;
        sink_hold = sink_hold - 1;
      end else if (no_gaps) begin
        out_tready <= 1'b1;
      end else begin
        if (stretch_left == 0) begin
          level        = ~level;
          stretch_left = level ? $urandom_range(1, 12) : pick_gap() + 1;
        end
        stretch_left--;
        out_tready <= level;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Hit-test edges, field extremes, start/pause from every run state, reset while running and while idle.
  task automatic test_tap_layout();
    send_item(CMD_TICK, 16'hFFFF, 9'h1FF, 8'hFF);  // tick while idle: no change
    send_item(CMD_TAP,  16'hFFFF, 9'd0,   8'd0);   // far corner: ignored
    send_item(CMD_TAP,  16'd0,    9'h1FF, 8'hFF);  // off screen: ignored
    send_item(CMD_TAP,  16'd0,    9'd16,  8'd146); // chip 0, top left edge
    send_item(CMD_TAP,  16'd0,    9'd85,  8'd190); // gap between chips
    send_item(CMD_TAP,  16'd0,    9'd312, 8'd190); // chip 3, bottom right edge
    send_item(CMD_TAP,  16'd0,    9'd50,  8'd145); // just above the chip row
    send_item(CMD_TAP,  16'd0,    9'd200, 8'd191); // between row and buttons
    send_item(CMD_TAP,  16'd0,    9'd16,  8'd192); // start: run, hide chips
    send_item(CMD_TAP,  16'd0,    9'd100, 8'd160); // chip while hidden: ignored
    send_item(CMD_TICK, 16'd0,    9'd0,   8'd0);   // zero elapsed
    send_item(CMD_TICK, 16'hFFFF, 9'd0,   8'd0);   // largest tick
    send_item(CMD_TAP,  16'd0,    9'd156, 8'hFF);  // start while running: pause
    send_item(CMD_TICK, 16'd1000, 9'd0,   8'd0);   // tick while paused: held
    send_item(CMD_TAP,  16'd0,    9'd80,  8'd200); // resume from pause
    send_item(CMD_TAP,  16'd0,    9'd157, 8'd200); // between buttons: ignored
    send_item(CMD_TAP,  16'd0,    9'd304, 8'd192); // reset, right edge
    send_item(CMD_TAP,  16'd0,    9'd164, 8'd240); // reset while idle
  endtask

  // Phase ends: exact zero, rounding up of the last second, break to idle,
  // and a zero-minute work length.
  task automatic test_phase_ends();
    load_lengths(7'd15, 7'd1, 7'd45, 7'd60, 7'd1);
    send_item(CMD_TAP,  16'd0,     9'd92, 8'd146); // chip 1: one minute
    send_item(CMD_TAP,  16'd0,     9'd16, 8'd255); // start
    send_item(CMD_TICK, 16'd59999, 9'd0,  8'd0);   // 1 ms left, 1 second shown
    send_item(CMD_TICK, 16'd1,     9'd0,  8'd0);   // hits zero: break loads
    send_item(CMD_TICK, 16'hFFFF,  9'd0,  8'd0);   // break over: idle work
    load_lengths(7'd0, 7'd1, 7'd45, 7'd60, 7'd1);
    send_item(CMD_TAP,  16'd0,     9'd84, 8'd190); // chip 0: zero length
    send_item(CMD_TAP,  16'd0,     9'd100, 8'd230);
    send_item(CMD_TICK, 16'd0,     9'd0,  8'd0);   // ends with no time elapsed
  endtask

  // Hold the result side off while items keep coming, so the input stalls.
  task automatic test_backpressure();
    settle_results();
    sink_hold = 80;
    no_gaps   = 1'b1;
    send_random(24);
    no_gaps   = 1'b0;
  endtask

  // Random items under several length settings, extremes among them.
  task automatic test_random_lengths();
    load_lengths(7'd15, 7'd25, 7'd45, 7'd60, 7'd5);
    send_random(150);
    load_lengths(7'd1, 7'd1, 7'd1, 7'd1, 7'd1);
    send_random(160);
    load_lengths(7'd0, 7'd127, 7'd1, 7'd99, 7'd0);
    send_random(160);
    load_lengths(7'd2, 7'd1, 7'd127, 7'd0, 7'd99);
    send_random(120);
    load_lengths(7'($urandom_range(0, 4)), 7'($urandom_range(0, 4)),
                 7'($urandom_range(0, 127)), 7'($urandom_range(0, 4)),
                 7'($urandom_range(0, 3)));
    send_random(150);
  endtask

  // Both sides at full rate: one item per cycle in and out.
  task automatic test_full_rate();
    settle_results();
    no_gaps = 1'b1;
    send_random(60);
    no_gaps = 1'b0;
  endtask

  initial begin
    reset_timer();
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_tap_layout();
    test_phase_ends();
    test_backpressure();
    test_random_lengths();
    test_full_rate();
    settle_results();
    // let any stray status item show up before the verdict
    repeat (20) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("tb_pomodoro_countdown_timer_top: clean");
    end else begin
      $display("tb_pomodoro_countdown_timer_top: errors");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest correct run.
  initial begin
    #12000000;
    $display("tb_pomodoro_countdown_timer_top: errors");
    $finish;
  end

endmodule
